// ===== sv/round_robin_task_scheduler_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the round-robin task scheduler.
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_TASK_SCHEDULER_UNIT_ASSERT_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRTS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and codes of the round-robin task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

    localparam int ID_W     = 5;
    localparam int PRIO_W   = 5;
    localparam int ACTION_W = 3;
    localparam int KIND_W   = 2;
    localparam int CODE_W   = 2;
    localparam int STAT_W   = 3;

    localparam int KERNEL_PRIORITY = 31;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CREATE   = 3'd0,
        ACT_CANCEL   = 3'd1,
        ACT_SCHEDULE = 3'd2,
        ACT_BLOCK    = 3'd3,
        ACT_UNBLOCK  = 3'd4,
        ACT_YIELD    = 3'd5
    } action_t;

    typedef enum logic [CODE_W-1:0] {
        RC_OK      = 2'd0,
        RC_NOSLOT  = 2'd1,
        RC_REFUSED = 2'd2,
        RC_FATAL   = 2'd3
    } result_code_t;

    localparam logic [STAT_W-1:0] SLOT_FREE  = 3'd0;
    localparam logic [STAT_W-1:0] SLOT_RUN   = 3'd1;
    localparam logic [STAT_W-1:0] SLOT_READY = 3'd2;
    localparam logic [STAT_W-1:0] SLOT_DIED  = 3'd3;
    localparam logic [STAT_W-1:0] SLOT_BLOCK = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CR_SCAN,
        ST_CR_LAST,
        ST_CAN_CHK,
        ST_CAN_FIN,
        ST_UB,
        ST_SW_SCAN,
        ST_SW_FREE,
        ST_SCH_CUR,
        ST_PICK,
        ST_PICK_FIN,
        ST_UNL_RD,
        ST_UNL_WR,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== sv/round_robin_task_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_unit
// Task table with a doubly linked ready queue, driven by a small sequencer.
// ----------------------------------------------------------------------------
// The input channel carries one scheduler action per transfer (create,
// cancel, schedule, block, unblock, yield); the output channel carries one
// result per action: a status code, the slot of a created task, the active
// task, its time slice and a switch flag.
// in_ready is high only while the sequencer is idle, so one action is in
// work at a time. An unknown action or a cancel of the kernel goes straight
// to the result; create scans the table for a free slot, and schedule, block
// and yield walk the whole table and free each dead task before they pick
// the next one. The sequencer walks the task table one slot per cycle,
// pausing to unlink each dead task it frees, and every queue unlink reads the
// link RAMs and then writes them only if the slot is queued. The next action
// can be taken in the cycle after a result is loaded.
// A finished result waits in the output register while the next action is
// worked on; a stalled receiver holds the following result, and the block
// with it, until the earlier one is taken.
// After reset slot 0, the kernel, is running with priority 31 and the queue
// is empty. Link RAM data is only used for queued slots.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_task_scheduler_unit #(
    parameter int MAX_TASKS     = 32,
    parameter int PRIORITY_BITS = 5
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [rrts_pkg::ACTION_W-1:0] action,
    input  wire logic [rrts_pkg::ID_W-1:0]     task_id,
    input  wire logic [rrts_pkg::PRIO_W-1:0]   priority_req,
    input  wire logic [rrts_pkg::KIND_W-1:0]   block_kind,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [rrts_pkg::CODE_W-1:0]   status_code,
    output logic      [rrts_pkg::ID_W-1:0]     new_task_id,
    output logic      [rrts_pkg::ID_W-1:0]     active_task,
    output logic      [rrts_pkg::PRIO_W-1:0]   slice_ticks,
    output logic                               switched
);

    localparam int IDW = $clog2(MAX_TASKS);
    localparam int PB  = PRIORITY_BITS;
    localparam logic [IDW-1:0] LAST = IDW'(MAX_TASKS - 1);
    localparam logic [PB-1:0]  KPRIO = PB'(rrts_pkg::KERNEL_PRIORITY);

    rrts_pkg::state_t state_reg, state_next, ret_reg, ret_next;

    logic [rrts_pkg::STAT_W-1:0] status_reg [MAX_TASKS];
    logic [rrts_pkg::STAT_W-1:0] status_next [MAX_TASKS];
    logic [PB-1:0]               prio_reg [MAX_TASKS];
    logic [PB-1:0]               prio_next [MAX_TASKS];
    logic [MAX_TASKS-1:0]        queued_reg, queued_next;

    logic [IDW-1:0] addr_reg, addr_next;
    logic [IDW-1:0] cur_reg, cur_next;
    logic [IDW-1:0] before_reg, before_next;
    logic [IDW-1:0] head_reg, head_next;
    logic [IDW-1:0] tail_reg, tail_next;
    logic           empty_reg, empty_next;
    logic [IDW-1:0] newid_reg, newid_next;
    rrts_pkg::result_code_t code_reg, code_next;

    logic [rrts_pkg::ACTION_W-1:0] act_reg, act_next;
    logic [rrts_pkg::ID_W-1:0]     tid_reg, tid_next;
    logic [rrts_pkg::PRIO_W-1:0]   preq_reg, preq_next;
    logic [rrts_pkg::KIND_W-1:0]   kind_reg, kind_next;

    logic                         out_valid_reg, out_valid_next;
    logic [rrts_pkg::CODE_W-1:0]  out_code_reg, out_code_next;
    logic [rrts_pkg::ID_W-1:0]    out_newid_reg, out_newid_next;
    logic [rrts_pkg::ID_W-1:0]    out_run_reg, out_run_next;
    logic [rrts_pkg::PRIO_W-1:0]  out_slice_reg, out_slice_next;
    logic                         out_sw_reg, out_sw_next;

    logic           nx_we, pv_we;
    logic [IDW-1:0] nx_waddr, pv_waddr, nx_wdata, pv_wdata;
    logic [IDW-1:0] nx_rdata, pv_rdata;

    logic [rrts_pkg::STAT_W-1:0] stat_q;
    logic                        queued_q;
    logic                        tid_oor;
    logic [IDW-1:0]              tid_idx;
    logic                        out_free;
    logic                        cancel_bad;
    logic                        cr_hit;

    assign stat_q     = status_reg[addr_reg];
    assign queued_q   = queued_reg[addr_reg];
    assign tid_oor    = ({27'd0, tid_reg} >= 32'(MAX_TASKS));
    assign tid_idx    = IDW'(tid_reg);
    assign out_free   = !out_valid_reg || out_ready;
    assign cancel_bad = tid_oor || (tid_reg == '0);
    assign cr_hit     = (stat_q == rrts_pkg::SLOT_FREE) && (addr_reg != cur_reg);

    rrts_ram #(.WIDTH(IDW), .DEPTH(MAX_TASKS)) u_next_ram (
        .clk   (clk),
        .we    (nx_we),
        .waddr (nx_waddr),
        .wdata (nx_wdata),
        .raddr (addr_reg),
        .rdata (nx_rdata)
    );

    rrts_ram #(.WIDTH(IDW), .DEPTH(MAX_TASKS)) u_prev_ram (
        .clk   (clk),
        .we    (pv_we),
        .waddr (pv_waddr),
        .wdata (pv_wdata),
        .raddr (addr_reg),
        .rdata (pv_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            rrts_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rrts_pkg::ST_DISPATCH;
                end
            end
            rrts_pkg::ST_DISPATCH:
            begin
                unique case (act_reg)
                    rrts_pkg::ACT_CREATE:
                    begin
                        state_next = rrts_pkg::ST_CR_SCAN;
                    end
                    rrts_pkg::ACT_CANCEL:
                    begin
                        state_next = cancel_bad ? rrts_pkg::ST_DONE : rrts_pkg::ST_CAN_CHK;
                    end
                    rrts_pkg::ACT_SCHEDULE, rrts_pkg::ACT_YIELD, rrts_pkg::ACT_BLOCK:
                    begin
                        state_next = rrts_pkg::ST_SW_SCAN;
                    end
                    rrts_pkg::ACT_UNBLOCK:
                    begin
                        state_next = tid_oor ? rrts_pkg::ST_DONE : rrts_pkg::ST_UB;
                    end
                    default:
                    begin
                        state_next = rrts_pkg::ST_DONE;
                    end
                endcase
            end
            rrts_pkg::ST_CR_SCAN:
            begin
                if (cr_hit)
                begin
                    state_next = rrts_pkg::ST_DONE;
                end
                else if (addr_reg == LAST)
                begin
                    state_next = rrts_pkg::ST_CR_LAST;
                end
            end
            rrts_pkg::ST_CR_LAST, rrts_pkg::ST_UB, rrts_pkg::ST_CAN_FIN,
            rrts_pkg::ST_PICK_FIN:
            begin
                state_next = rrts_pkg::ST_DONE;
            end
            rrts_pkg::ST_CAN_CHK:
            begin
                if (stat_q == rrts_pkg::SLOT_FREE)
                begin
                    state_next = rrts_pkg::ST_DONE;
                end
                else
                begin
                    state_next = rrts_pkg::ST_UNL_RD;
                    ret_next   = rrts_pkg::ST_CAN_FIN;
                end
            end
            rrts_pkg::ST_SW_SCAN:
            begin
                if (stat_q == rrts_pkg::SLOT_DIED)
                begin
                    state_next = rrts_pkg::ST_UNL_RD;
                    ret_next   = rrts_pkg::ST_SW_FREE;
                end
                else if (addr_reg == LAST)
                begin
                    state_next = rrts_pkg::ST_SCH_CUR;
                end
            end
            rrts_pkg::ST_SW_FREE:
            begin
                state_next = (addr_reg == LAST) ? rrts_pkg::ST_SCH_CUR : rrts_pkg::ST_SW_SCAN;
            end
            rrts_pkg::ST_SCH_CUR:
            begin
                if (stat_q == rrts_pkg::SLOT_RUN)
                begin
                    state_next = empty_reg ? rrts_pkg::ST_DONE : rrts_pkg::ST_PICK;
                end
                else if (stat_q == rrts_pkg::SLOT_READY)
                begin
                    state_next = rrts_pkg::ST_PICK;
                end
                else
                begin
                    state_next = rrts_pkg::ST_UNL_RD;
                    ret_next   = rrts_pkg::ST_PICK;
                end
            end
            rrts_pkg::ST_PICK:
            begin
                if (empty_reg)
                begin
                    state_next = rrts_pkg::ST_DONE;
                end
                else
                begin
                    state_next = rrts_pkg::ST_UNL_RD;
                    ret_next   = rrts_pkg::ST_PICK_FIN;
                end
            end
            rrts_pkg::ST_UNL_RD:
            begin
                state_next = queued_q ? rrts_pkg::ST_UNL_WR : ret_reg;
            end
            rrts_pkg::ST_UNL_WR:
            begin
                state_next = ret_reg;
            end
            rrts_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = rrts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rrts_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        status_next    = status_reg;
        prio_next      = prio_reg;
        queued_next    = queued_reg;
        addr_next      = addr_reg;
        cur_next       = cur_reg;
        before_next    = before_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        empty_next     = empty_reg;
        newid_next     = newid_reg;
        code_next      = code_reg;
        act_next       = act_reg;
        tid_next       = tid_reg;
        preq_next      = preq_reg;
        kind_next      = kind_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_code_next  = out_code_reg;
        out_newid_next = out_newid_reg;
        out_run_next   = out_run_reg;
        out_slice_next = out_slice_reg;
        out_sw_next    = out_sw_reg;
        nx_we          = 1'b0;
        nx_waddr       = addr_reg;
        nx_wdata       = head_reg;
        pv_we          = 1'b0;
        pv_waddr       = addr_reg;
        pv_wdata       = tail_reg;
        in_ready       = (state_reg == rrts_pkg::ST_IDLE);

        unique case (state_reg)
            rrts_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next    = action;
                    tid_next    = task_id;
                    preq_next   = priority_req;
                    kind_next   = block_kind;
                    before_next = cur_reg;
                    code_next   = rrts_pkg::RC_OK;
                    newid_next  = '0;
                end
            end
            rrts_pkg::ST_DISPATCH:
            begin
                addr_next = '0;
                unique case (act_reg)
                    rrts_pkg::ACT_CANCEL:
                    begin
                        if (cancel_bad)
                        begin
                            code_next = rrts_pkg::RC_REFUSED;
                        end
                        addr_next = tid_idx;
                    end
                    rrts_pkg::ACT_BLOCK:
                    begin
                        status_next[cur_reg] = rrts_pkg::SLOT_BLOCK | {1'b0, kind_reg};
                    end
                    rrts_pkg::ACT_UNBLOCK:
                    begin
                        if (tid_oor)
                        begin
                            code_next = rrts_pkg::RC_REFUSED;
                        end
                        addr_next = tid_idx;
                    end
                    default:
                    begin
                    end
                endcase
            end
            rrts_pkg::ST_CR_SCAN, rrts_pkg::ST_CR_LAST:
            begin
                if (cr_hit || (state_reg == rrts_pkg::ST_CR_LAST &&
                               stat_q == rrts_pkg::SLOT_FREE))
                begin
                    status_next[addr_reg] = rrts_pkg::SLOT_READY;
                    prio_next[addr_reg]   = PB'(preq_reg);
                    newid_next            = addr_reg;
                    queued_next[addr_reg] = 1'b1;
                    if (empty_reg)
                    begin
                        head_next  = addr_reg;
                        tail_next  = addr_reg;
                        empty_next = 1'b0;
                    end
                    else
                    begin
                        nx_we     = 1'b1;
                        pv_we     = 1'b1;
                        pv_waddr  = head_reg;
                        pv_wdata  = addr_reg;
                        head_next = addr_reg;
                    end
                end
                else if (state_reg == rrts_pkg::ST_CR_LAST)
                begin
                    code_next = rrts_pkg::RC_NOSLOT;
                end
                else if (addr_reg == LAST)
                begin
                    addr_next = cur_reg;
                end
                else
                begin
                    addr_next = addr_reg + IDW'(1);
                end
            end
            rrts_pkg::ST_CAN_CHK:
            begin
                if (stat_q == rrts_pkg::SLOT_FREE)
                begin
                    code_next = rrts_pkg::RC_REFUSED;
                end
            end
            rrts_pkg::ST_CAN_FIN:
            begin
                status_next[addr_reg] = (addr_reg == cur_reg) ? rrts_pkg::SLOT_DIED
                                                              : rrts_pkg::SLOT_FREE;
            end
            rrts_pkg::ST_UB:
            begin
                if (stat_q == rrts_pkg::SLOT_FREE || stat_q == rrts_pkg::SLOT_DIED)
                begin
                    code_next = rrts_pkg::RC_REFUSED;
                end
                else if (stat_q >= rrts_pkg::SLOT_BLOCK)
                begin
                    if (queued_q)
                    begin
                        code_next = rrts_pkg::RC_FATAL;
                    end
                    else
                    begin
                        status_next[addr_reg] = rrts_pkg::SLOT_READY;
                        queued_next[addr_reg] = 1'b1;
                        if (empty_reg)
                        begin
                            head_next  = addr_reg;
                            tail_next  = addr_reg;
                            empty_next = 1'b0;
                        end
                        else
                        begin
                            nx_we     = 1'b1;
                            pv_we     = 1'b1;
                            pv_waddr  = head_reg;
                            pv_wdata  = addr_reg;
                            head_next = addr_reg;
                        end
                    end
                end
            end
            rrts_pkg::ST_SW_SCAN, rrts_pkg::ST_SW_FREE:
            begin
                if (state_reg == rrts_pkg::ST_SW_FREE)
                begin
                    status_next[addr_reg] = rrts_pkg::SLOT_FREE;
                end
                if (state_reg == rrts_pkg::ST_SW_SCAN && stat_q == rrts_pkg::SLOT_DIED)
                begin
                    addr_next = addr_reg;
                end
                else if (addr_reg == LAST)
                begin
                    addr_next = cur_reg;
                end
                else
                begin
                    addr_next = addr_reg + IDW'(1);
                end
            end
            rrts_pkg::ST_SCH_CUR:
            begin
                if (stat_q == rrts_pkg::SLOT_RUN && !empty_reg)
                begin
                    status_next[addr_reg] = rrts_pkg::SLOT_READY;
                    if (!queued_q)
                    begin
                        queued_next[addr_reg] = 1'b1;
                        nx_we     = 1'b1;
                        nx_waddr  = tail_reg;
                        nx_wdata  = addr_reg;
                        pv_we     = 1'b1;
                        tail_next = addr_reg;
                    end
                end
            end
            rrts_pkg::ST_PICK:
            begin
                addr_next = head_reg;
            end
            rrts_pkg::ST_PICK_FIN:
            begin
                status_next[addr_reg] = rrts_pkg::SLOT_RUN;
                cur_next              = addr_reg;
            end
            rrts_pkg::ST_UNL_WR:
            begin
                queued_next[addr_reg] = 1'b0;
                if (head_reg == addr_reg && tail_reg == addr_reg)
                begin
                    empty_next = 1'b1;
                end
                else if (head_reg == addr_reg)
                begin
                    head_next = nx_rdata;
                end
                else if (tail_reg == addr_reg)
                begin
                    tail_next = pv_rdata;
                end
                else
                begin
                    nx_we    = 1'b1;
                    nx_waddr = pv_rdata;
                    nx_wdata = nx_rdata;
                    pv_we    = 1'b1;
                    pv_waddr = nx_rdata;
                    pv_wdata = pv_rdata;
                end
            end
            rrts_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_code_next  = code_reg;
                    out_newid_next = rrts_pkg::ID_W'(newid_reg);
                    out_run_next   = rrts_pkg::ID_W'(cur_reg);
                    out_slice_next = rrts_pkg::PRIO_W'(prio_reg[cur_reg]);
                    out_sw_next    = (cur_reg != before_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rrts_pkg::ST_IDLE;
            ret_reg       <= rrts_pkg::ST_IDLE;
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                status_reg[i] <= (i == 0) ? rrts_pkg::SLOT_RUN : rrts_pkg::SLOT_FREE;
                prio_reg[i]   <= (i == 0) ? KPRIO : '0;
            end
            queued_reg    <= '0;
            cur_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            status_reg    <= status_next;
            prio_reg      <= prio_next;
            queued_reg    <= queued_next;
            cur_reg       <= cur_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        before_reg    <= before_next;
        newid_reg     <= newid_next;
        code_reg      <= code_next;
        act_reg       <= act_next;
        tid_reg       <= tid_next;
        preq_reg      <= preq_next;
        kind_reg      <= kind_next;
        out_code_reg  <= out_code_next;
        out_newid_reg <= out_newid_next;
        out_run_reg   <= out_run_next;
        out_slice_reg <= out_slice_next;
        out_sw_reg    <= out_sw_next;
    end

    assign out_valid   = out_valid_reg;
    assign status_code = out_code_reg;
    assign new_task_id = out_newid_reg;
    assign active_task = out_run_reg;
    assign slice_ticks = out_slice_reg;
    assign switched    = out_sw_reg;

endmodule

`default_nettype wire

// ===== sv/rrts_ram.sv =====
// ----------------------------------------------------------------------------
// rrts_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/rrts_checker.sv =====
// ----------------------------------------------------------------------------
// rrts_checker
// Port-level checks of the round-robin task scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "round_robin_task_scheduler_unit_assert.svh"

module rrts_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [rrts_pkg::CODE_W-1:0] status_code,
    input wire logic [rrts_pkg::ID_W-1:0]   new_task_id,
    input wire logic [rrts_pkg::ID_W-1:0]   active_task,
    input wire logic                        switched
);

    `RRTS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after transfer")
    `RRTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(active_task), "result dropped")
    `RRTS_ASSERT_SAME(a_newid_ok, out_valid && new_task_id != '0, status_code == rrts_pkg::RC_OK, "slot with error")
    `RRTS_ASSERT_SAME(a_err_no_switch, out_valid && status_code != rrts_pkg::RC_OK, !switched, "switch on error")

endmodule

bind round_robin_task_scheduler_unit rrts_checker u_rrts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status_code (status_code),
    .new_task_id (new_task_id),
    .active_task (active_task),
    .switched    (switched)
);

`default_nettype wire

// ===== bench/round_robin_task_scheduler_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result checker for the round-robin task scheduler
// Watches both channels, keeps its own copy of the task table and the ready
// queue, predicts the result of every accepted action and compares it field
// by field with the result the block returns.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_unit_checker
    import rrts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [ACTION_W-1:0] action,
    input  logic [ID_W-1:0]     task_id,
    input  logic [PRIO_W-1:0]   priority_req,
    input  logic [KIND_W-1:0]   block_kind,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [CODE_W-1:0]   status_code,
    input  logic [ID_W-1:0]     new_task_id,
    input  logic [ID_W-1:0]     active_task,
    input  logic [PRIO_W-1:0]   slice_ticks,
    input  logic                switched,
    output int                  fail_count,
    output int                  pending_count
);

    localparam int NSLOT = 32;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [ID_W-1:0]   new_id;
        logic [ID_W-1:0]   running;
        logic [PRIO_W-1:0] slice;
        logic              sw;
    } sched_result_t;

    logic [STAT_W-1:0] tbl_status [NSLOT];
    logic [PRIO_W-1:0] tbl_prio [NSLOT];
    logic [ID_W-1:0]   nxt [NSLOT];
    logic [ID_W-1:0]   prv [NSLOT];
    logic              queued [NSLOT];
    logic [ID_W-1:0]   head;
    logic [ID_W-1:0]   tail;
    logic              empty;
    logic [ID_W-1:0]   cur;
    sched_result_t     awaited [$];

    function automatic void push_head(logic [ID_W-1:0] s);
        queued[s] = 1'b1;
        if (empty)
        begin
            head = s;
            tail = s;
            empty = 1'b0;
        end
        else
        begin
            nxt[s] = head;
            prv[head] = s;
            head = s;
        end
    endfunction

    function automatic void push_tail(logic [ID_W-1:0] s);
        queued[s] = 1'b1;
        if (empty)
        begin
            head = s;
            tail = s;
            empty = 1'b0;
        end
        else
        begin
            prv[s] = tail;
            nxt[tail] = s;
            tail = s;
        end
    endfunction

    function automatic void unlink(logic [ID_W-1:0] s);
        if (queued[s])
        begin
            queued[s] = 1'b0;
            if (head == s && tail == s)
                empty = 1'b1;
            else if (head == s)
                head = nxt[s];
            else if (tail == s)
                tail = prv[s];
            else
            begin
                nxt[prv[s]] = nxt[s];
                prv[nxt[s]] = prv[s];
            end
        end
    endfunction

    function automatic void reschedule();
        logic [ID_W-1:0] c;
        logic [STAT_W-1:0] st;
        c = cur;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (tbl_status[i] == SLOT_DIED)
            begin
                unlink(ID_W'(i));
                tbl_status[i] = SLOT_FREE;
            end
        end
        st = tbl_status[c];
        if (st == SLOT_RUN)
        begin
            if (empty)
                return;
            if (!queued[c])
                push_tail(c);
            tbl_status[c] = SLOT_READY;
        end
        else if (st != SLOT_READY)
            unlink(c);
        if (empty)
            return;
        c = head;
        unlink(c);
        tbl_status[c] = SLOT_RUN;
        cur = c;
    endfunction

    function automatic sched_result_t apply_action(logic [ACTION_W-1:0] act,
        logic [ID_W-1:0] tid, logic [PRIO_W-1:0] pr, logic [KIND_W-1:0] kind);
        sched_result_t r;
        logic [ID_W-1:0] was;
        logic found;
        was = cur;
        r = '0;
        r.code = RC_OK;
        case (act)
            ACT_CREATE:
            begin
                found = 1'b0;
                for (int pass = 0; pass < 2 && !found; pass++)
                begin
                    for (int i = 0; i < NSLOT && !found; i++)
                    begin
                        if (tbl_status[i] == SLOT_FREE && (pass == 1 || i != cur))
                        begin
                            tbl_status[i] = SLOT_READY;
                            tbl_prio[i] = pr;
                            push_head(ID_W'(i));
                            r.new_id = ID_W'(i);
                            found = 1'b1;
                        end
                    end
                end
                if (!found)
                    r.code = RC_NOSLOT;
            end
            ACT_CANCEL:
            begin
                if (tid == 0 || tbl_status[tid] == SLOT_FREE)
                    r.code = RC_REFUSED;
                else
                begin
                    unlink(tid);
                    tbl_status[tid] = (tid == cur) ? SLOT_DIED : SLOT_FREE;
                end
            end
            ACT_SCHEDULE, ACT_YIELD:
                reschedule();
            ACT_BLOCK:
            begin
                tbl_status[cur] = SLOT_BLOCK + STAT_W'(kind);
                reschedule();
            end
            ACT_UNBLOCK:
            begin
                if (tbl_status[tid] == SLOT_FREE || tbl_status[tid] == SLOT_DIED)
                    r.code = RC_REFUSED;
                else if (tbl_status[tid] >= SLOT_BLOCK)
                begin
                    if (queued[tid])
                        r.code = RC_FATAL;
                    else
                    begin
                        push_head(tid);
                        tbl_status[tid] = SLOT_READY;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.running = cur;
        r.slice = tbl_prio[cur];
        r.sw = (cur != was);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NSLOT; i++)
            begin
                tbl_status[i] = SLOT_FREE;
                tbl_prio[i] = '0;
                nxt[i] = '0;
                prv[i] = '0;
                queued[i] = 1'b0;
            end
            tbl_status[0] = SLOT_RUN;
            tbl_prio[0] = PRIO_W'(KERNEL_PRIORITY);
            head = '0;
            tail = '0;
            empty = 1'b1;
            cur = '0;
            awaited.delete();
            fail_count <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (status_code !== want.code)
                        $error("status_code: expected %0d, got %0d", want.code, status_code);
                    if (new_task_id !== want.new_id)
                        $error("new_task_id: expected %0d, got %0d", want.new_id, new_task_id);
                    if (active_task !== want.running)
                        $error("active_task: expected %0d, got %0d", want.running,
                               active_task);
                    if (slice_ticks !== want.slice)
                        $error("slice_ticks: expected %0d, got %0d", want.slice, slice_ticks);
                    if (switched !== want.sw)
                        $error("switched: expected %0d, got %0d", want.sw, switched);
                    if (status_code !== want.code || new_task_id !== want.new_id
                        || active_task !== want.running || slice_ticks !== want.slice
                        || switched !== want.sw)
                        fail_count <= fail_count + 1;
                end
            end
            if (in_valid && in_ready)
                awaited.push_back(apply_action(action, task_id, priority_req, block_kind));
            pending_count <= awaited.size();
        end
    end

endmodule

// ===== bench/round_robin_task_scheduler_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench top for the round-robin task scheduler
// Drives directed and random scheduler actions with random idle cycles on
// both channels and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_unit_tb;
    import rrts_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [ACTION_W-1:0] action = '0;
    logic [ID_W-1:0]     task_id = '0;
    logic [PRIO_W-1:0]   priority_req = '0;
    logic [KIND_W-1:0]   block_kind = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [CODE_W-1:0]   status_code;
    logic [ID_W-1:0]     new_task_id;
    logic [ID_W-1:0]     active_task;
    logic [PRIO_W-1:0]   slice_ticks;
    logic                switched;
    int                  fail_count;
    int                  pending_count;
    int                  idle_pct = 27;
    int                  quiet_cycles = 0;

    localparam int QUIET_LIMIT = 20000;
    localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    round_robin_task_scheduler_unit dut (.*);

    round_robin_task_scheduler_unit_checker checker_i (.*);

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= idle_pct);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL round_robin_task_scheduler_unit");
            $finish;
        end
    end

    task automatic send_action(logic [ACTION_W-1:0] act, logic [ID_W-1:0] tid,
                               logic [PRIO_W-1:0] pr, logic [KIND_W-1:0] kind);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        task_id <= tid;
        priority_req <= pr;
        block_kind <= kind;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
    endtask

    task automatic send_random();
        int pick;
        logic [ACTION_W-1:0] act;
        pick = $urandom_range(99);
        if (pick < 30)
            act = ACT_CREATE;
        else if (pick < 45)
            act = ACT_CANCEL;
        else if (pick < 60)
            act = ACT_SCHEDULE;
        else if (pick < 72)
            act = ACT_BLOCK;
        else if (pick < 87)
            act = ACT_UNBLOCK;
        else if (pick < 97)
            act = ACT_YIELD;
        else
            act = ACTION_W'($urandom_range(7));
        send_action(act, ID_W'($urandom), PRIO_W'($urandom), KIND_W'($urandom));
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_action(ACT_CANCEL, '0, '0, '0);
        send_action(ACT_UNBLOCK, '0, '0, '0);
        send_action(ACT_CANCEL, 5'd5, '0, '0);
        send_action(ACT_UNBLOCK, 5'd31, '0, '0);
        send_action(ACT_SCHEDULE, '0, '0, '0);
        send_action(ACT_CREATE, '0, 5'd31, '0);
        send_action(ACT_CREATE, '0, '0, '0);
        send_action(ACT_CREATE, '0, 5'd17, '0);
        send_action(ACT_YIELD, '0, '0, '0);
        send_action(ACT_SCHEDULE, '0, '0, '0);
        send_action(ACT_BLOCK, '0, '0, 2'd3);
        send_action(ACT_UNBLOCK, '0, '0, '0);
        send_action(ACT_UNBLOCK, '0, '0, '0);
        send_action(ACT_CANCEL, 5'd2, '0, '0);
        send_action(ACT_SCHEDULE, '0, '0, '0);
        send_action(ACT_SPARE_LO, 5'd31, 5'd31, 2'd3);
        send_action(ACT_SPARE_HI, '0, '0, '0);
        send_action(ACT_BLOCK, '0, '0, 2'd1);
        send_action(ACT_BLOCK, '0, '0, 2'd2);
        send_action(ACT_BLOCK, '0, '0, '0);
        send_action(ACT_SCHEDULE, '0, '0, '0);
        send_action(ACT_UNBLOCK, 5'd1, '0, '0);
        for (int i = 0; i < 33; i++)
            send_action(ACT_CREATE, '0, PRIO_W'(i), '0);
        send_action(ACT_CANCEL, 5'd31, '0, '0);

        drain();

        for (int i = 0; i < 1150; i++)
        begin
            idle_pct = (i >= 400 && i < 600) ? 0 : 27;
            if (i == 800)
            begin
                drain();
            end
            send_random();
        end
        idle_pct = 27;

        drain();
        repeat (200) @(negedge clk);
        if (fail_count == 0)
            $display("PASS round_robin_task_scheduler_unit");
        else
            $display("FAIL round_robin_task_scheduler_unit");
        $finish;
    end

endmodule
